// ===== rtl/ptgp_pkg.sv =====
// Shared types and constants for the pixel-to-ground projection block.
// No dependencies; imported by every module of the block.
package ptgp_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 54;

    localparam logic [CFG_ADDR_W-1:0] REG_PRINCIPAL = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_ROW0  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_ROW1  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_ROW2  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_XY = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_PAR_LIMIT = 3'd7;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_PARALLEL = 2'd1;
    localparam logic [1:0] STATUS_BEHIND   = 2'd2;

    // ray components saturate to signed 40 bits before scaling by height
    localparam int RAY_W = 40;
    localparam longint RAY_MAX = 64'sd549755813887;
    localparam longint RAY_MIN = -64'sd549755813888;

    // divider: numerator -h*b, denominator bz, quotient bits kept before saturating
    localparam int NUM_W = 64;
    localparam int DEN_W = 46;
    localparam int QUO_W = 34;
    localparam int CMP_W = DEN_W + QUO_W;
    localparam int DIV_LAT = QUO_W + 1;

    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } ptgp_quo_t;

endpackage

// ===== rtl/ptgp_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
// Depends on ptgp_pkg. One transaction per cycle while en is high.
module ptgp_divider (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [ptgp_pkg::NUM_W-1:0] num,
    input  logic signed [ptgp_pkg::DEN_W-1:0] den,
    output ptgp_pkg::ptgp_quo_t           res
);
    import ptgp_pkg::*;

    logic [NUM_W-1:0] rem_reg [0:QUO_W];
    logic [DEN_W-1:0] d_reg   [0:QUO_W];
    logic [QUO_W-1:0] q_reg   [0:QUO_W];
    logic             neg_reg [0:QUO_W];
    logic             ovf_reg [0:QUO_W];

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;

    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_mag;
            d_reg[0]   <= den_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
            ovf_reg[0] <= CMP_W'(num_mag) >= (CMP_W'(den_mag) << QUO_W);
        end
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_stage
        logic [CMP_W-1:0] sub;
        logic             ge;
        assign sub = CMP_W'(d_reg[k-1]) << (QUO_W - k);
        assign ge  = CMP_W'(rem_reg[k-1]) >= sub;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? rem_reg[k-1] - sub[NUM_W-1:0] : rem_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (QUO_W'(ge) << (QUO_W - k));
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign res.quo = ovf_reg[QUO_W] ? '1 : q_reg[QUO_W];
    assign res.neg = neg_reg[QUO_W];
    assign res.ovf = ovf_reg[QUO_W];
endmodule

// ===== rtl/pixel_to_ground_projection.sv =====
// Top level of the pixel-to-ground projection pipeline.
// Depends on ptgp_pkg and ptgp_divider.
//
// Usage:
//  s_* channel: one pixel per transaction, s_tdata = {pixel_v, pixel_u}.
//  m_* channel: one result per pixel, m_tuser = status,
//   m_tdata = {ground_y, ground_x}, signed Q16.16 metres.
//  cfg_*: register writes, one per cycle when cfg_we is high; only while idle.
//  Throughput is one transaction per cycle while the output is not stalled. The
//  pipeline is four stages for ray forming, rotation and scaling, then the
//  bit-per-stage divider for the plane intersection, and the output register.
//  Reset clears all valid flags and loads register defaults (parallel limit 1,
//  all else 0). When m_tready is low with a result held, the whole pipeline
//  freezes and s_tready drops; nothing is lost or repeated.
module pixel_to_ground_projection #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((2*PIXEL_BITS+7)/8)*8-1:0] s_tdata,  // pixel_u, pixel_v
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,  // ground_x, ground_y
    output logic [1:0]                        m_tuser,  // status
    input  logic                              cfg_we,
    input  logic [ptgp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ptgp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ptgp_pkg::*;

    localparam int DIFF_W = PIXEL_BITS + 9;
    localparam int PROD_W = DIFF_W + 24;
    localparam int DX_W   = PROD_W - 8;
    localparam int TERM_W = DX_W + 18;
    localparam int ACC_W  = TERM_W + 2;
    localparam int B_W    = ACC_W - 16;

    // configuration registers
    logic [39:0] pp_reg;
    logic [47:0] ifoc_reg;
    logic [53:0] rot_reg [0:2];
    logic [47:0] off_reg;
    logic [23:0] h_reg;
    logic [15:0] lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg     <= '0;
            ifoc_reg   <= '0;
            rot_reg[0] <= '0;
            rot_reg[1] <= '0;
            rot_reg[2] <= '0;
            off_reg    <= '0;
            h_reg      <= '0;
            lim_reg    <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PRINCIPAL: pp_reg     <= cfg_wdata[39:0];
                REG_INV_FOCAL: ifoc_reg   <= cfg_wdata[47:0];
                REG_ROT_ROW0:  rot_reg[0] <= cfg_wdata;
                REG_ROT_ROW1:  rot_reg[1] <= cfg_wdata;
                REG_ROT_ROW2:  rot_reg[2] <= cfg_wdata;
                REG_OFFSET_XY: off_reg    <= cfg_wdata[47:0];
                REG_HEIGHT:    h_reg      <= cfg_wdata[23:0];
                REG_PAR_LIMIT: lim_reg    <= cfg_wdata[15:0];
                default:       lim_reg    <= lim_reg;
            endcase
        end
    end

    logic signed [23:0] h, tx, ty;
    assign h  = $signed(h_reg);
    assign tx = $signed(off_reg[23:0]);
    assign ty = $signed(off_reg[47:24]);

    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // stage 1: centered pixel times reciprocal focal length
    logic [PIXEL_BITS-1:0] u, v;
    logic signed [DIFF_W-1:0] du, dv;
    logic signed [PROD_W-1:0] px_reg, py_reg;
    logic v1_reg;

    assign u  = s_tdata[PIXEL_BITS-1:0];
    assign v  = s_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
    assign du = $signed(DIFF_W'({u, 8'b0})) - $signed(DIFF_W'(pp_reg[19:0]));
    assign dv = $signed(DIFF_W'({v, 8'b0})) - $signed(DIFF_W'(pp_reg[39:20]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= du * $signed({1'b0, ifoc_reg[23:0]});
            py_reg <= dv * $signed({1'b0, ifoc_reg[47:24]});
        end
    end

    // stage 2: rotation products
    logic signed [DX_W-1:0] dx, dy;
    logic signed [TERM_W-1:0] tax_reg [0:2];
    logic signed [TERM_W-1:0] tay_reg [0:2];
    logic v2_reg;

    assign dx = DX_W'(px_reg >>> 8);
    assign dy = DX_W'(py_reg >>> 8);

    // stage 3: sums, ray in Q.24
    logic signed [B_W-1:0] b_reg [0:2];
    logic v3_reg;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        logic signed [17:0] ca, cb, cc;
        logic signed [ACC_W-1:0] acc;
        assign ca  = $signed(rot_reg[r][17:0]);
        assign cb  = $signed(rot_reg[r][35:18]);
        assign cc  = $signed(rot_reg[r][53:36]);
        assign acc = ACC_W'(tax_reg[r]) + ACC_W'(tay_reg[r]) + (ACC_W'(cc) <<< 24);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tax_reg[r] <= ca * dx;
                tay_reg[r] <= cb * dy;
                b_reg[r]   <= B_W'(acc >>> 16);
            end
        end
    end

    // stage 4: clamp, scale by height, classify
    logic signed [RAY_W-1:0] bx_c, by_c;
    logic signed [63:0] bx64, by64, bz64;
    logic signed [24:0] nh;
    logic [63:0] abz;
    logic [1:0] status;
    logic signed [NUM_W-1:0] nx_reg, ny_reg;
    logic signed [DEN_W-1:0] bz_reg;
    logic [1:0] st4_reg;
    logic v4_reg;

    always_comb
    begin
        bx64 = 64'(b_reg[0]);
        by64 = 64'(b_reg[1]);
        bz64 = 64'(b_reg[2]);
        bx_c = (bx64 > RAY_MAX) ? RAY_W'(RAY_MAX) :
               (bx64 < RAY_MIN) ? RAY_W'(RAY_MIN) : RAY_W'(bx64);
        by_c = (by64 > RAY_MAX) ? RAY_W'(RAY_MAX) :
               (by64 < RAY_MIN) ? RAY_W'(RAY_MIN) : RAY_W'(by64);
        nh   = -25'(h);
        abz  = bz64[63] ? 64'(-bz64) : 64'(bz64);
        if (bz64 == 64'sd0 || abz < 64'(lim_reg))
            status = STATUS_PARALLEL;
        else if (h != 24'sd0 && ((h > 24'sd0) == (bz64 > 64'sd0)))
            status = STATUS_BEHIND;
        else
            status = STATUS_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= nh * bx_c;
            ny_reg  <= nh * by_c;
            bz_reg  <= DEN_W'(b_reg[2]);
            st4_reg <= status;
        end
    end

    // intersection: divide by bz
    ptgp_quo_t qx, qy;

    ptgp_divider u_div_x (.clk(clk), .en(en), .num(nx_reg), .den(bz_reg), .res(qx));
    ptgp_divider u_div_y (.clk(clk), .en(en), .num(ny_reg), .den(bz_reg), .res(qy));

    logic [DIV_LAT-1:0] vd_reg;
    logic [1:0] std_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            std_reg[0] <= st4_reg;
            for (int i = 1; i < DIV_LAT; i++)
                std_reg[i] <= std_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            vd_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            vd_reg       <= {vd_reg[DIV_LAT-2:0], v4_reg};
            m_tvalid_reg <= vd_reg[DIV_LAT-1];
        end
    end

    // output: sign, offset, saturate; zero unless status is OK
    logic signed [35:0] qsx, qsy;
    logic signed [36:0] sx, sy;
    logic signed [31:0] gx, gy;
    logic ok;
    logic [31:0] gx_reg, gy_reg;
    logic [1:0] st_reg;

    always_comb
    begin
        qsx = qx.neg ? -$signed({2'b0, qx.quo}) : $signed({2'b0, qx.quo});
        qsy = qy.neg ? -$signed({2'b0, qy.quo}) : $signed({2'b0, qy.quo});
        sx  = 37'(tx) + 37'(qsx);
        sy  = 37'(ty) + 37'(qsy);
        gx  = (sx > 37'sh7FFFFFFF) ? 32'sh7FFFFFFF :
              (sx < -37'sh80000000) ? 32'sh80000000 : 32'(sx);
        gy  = (sy > 37'sh7FFFFFFF) ? 32'sh7FFFFFFF :
              (sy < -37'sh80000000) ? 32'sh80000000 : 32'(sy);
        ok  = std_reg[DIV_LAT-1] == STATUS_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_reg <= ok ? gx : '0;
            gy_reg <= ok ? gy : '0;
            st_reg <= std_reg[DIV_LAT-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {gy_reg, gx_reg};
    assign m_tuser  = st_reg;
endmodule
